>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the core RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Check that an expression is never true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

>>> rtl/core/pdq_pkg.sv
// ---------------------------------------------------------------------------
// pdq_pkg
// Types, sizes and codes shared by the positional deque core.
// ---------------------------------------------------------------------------
package pdq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    // Fixed widths of the beat fields
    localparam int OP_W    = 3;
    localparam int POS_W   = 5;
    localparam int FIELD_W = 32;
    localparam int TOTAL_W = 5;

    // Derived sizes
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic [DATA_WIDTH-1:0] word_t;
    typedef logic [FIELD_W-1:0]    data_field_t;
    typedef logic [TOTAL_W-1:0]    total_field_t;
    typedef logic [CNT_W-1:0]      count_t;
    typedef logic [IDX_W-1:0]      index_t;
    typedef logic [CMP_W-1:0]      cmp_t;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_HEAD = 3'd0,
        OP_PUSH_TAIL = 3'd1,
        OP_INSERT    = 3'd2,
        OP_POP_HEAD  = 3'd3,
        OP_POP_TAIL  = 3'd4,
        OP_REMOVE    = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [POS_W-1:0] position;
        data_field_t      data_in;
    } in_item_t;

    typedef struct packed {
        data_field_t      data_out;
        logic [1:0]       status;
        total_field_t     entry_total;
        logic             is_empty;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        logic    place;
        logic    take;
        logic    emit;
        status_t res_status;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_push;
        logic is_pop;
        logic full;
        logic empty;
        logic pos_ok;
    } dp_status_t;

endpackage

>>> rtl/core/pdq_ctrl.sv
// ---------------------------------------------------------------------------
// pdq_ctrl
// Sequencer: takes a beat, picks the action and the status, emits the result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pdq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    input  pdq_pkg::dp_status_t dp_status,
    output pdq_pkg::dp_cmd_t    dp_cmd
);

    pdq_pkg::state_t state_reg, state_next;
    logic            done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pdq_pkg::S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        done_next         = 1'b0;
        dp_cmd            = '0;
        dp_cmd.res_status = pdq_pkg::ST_OK;
        unique case (state_reg)
            pdq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    dp_cmd.load = 1'b1;
                    state_next  = pdq_pkg::S_EXEC;
                end
            end
            pdq_pkg::S_EXEC:
            begin
                dp_cmd.emit = 1'b1;
                done_next   = 1'b1;
                state_next  = pdq_pkg::S_IDLE;
                if (dp_status.is_push)
                begin
                    // drop the word when full
                    if (dp_status.full)
                        dp_cmd.res_status = pdq_pkg::ST_FULL;
                    else
                        dp_cmd.place = 1'b1;
                end
                else if (dp_status.is_pop)
                begin
                    if (dp_status.empty)
                        dp_cmd.res_status = pdq_pkg::ST_EMPTY;
                    else if (!dp_status.pos_ok)
                        dp_cmd.res_status = pdq_pkg::ST_BADPOS;
                    else
                        dp_cmd.take = 1'b1;
                end
            end
            default:
            begin
                state_next = pdq_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != pdq_pkg::S_IDLE);
    assign done = done_reg;

    `ASSERT_PROP(a_load_then_emit, clk, rst_n, dp_cmd.load |=> dp_cmd.emit)
    `ASSERT_NEVER(a_place_and_take, clk, rst_n, dp_cmd.place && dp_cmd.take)
    `ASSERT_PROP(a_emit_then_done, clk, rst_n, dp_cmd.emit |=> done)

endmodule

>>> rtl/core/pdq_datapath.sv
// ---------------------------------------------------------------------------
// pdq_datapath
// Slot cells, occupancy count, index decode and the result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pdq_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  pdq_pkg::in_item_t   cmd_in,
    input  pdq_pkg::dp_cmd_t    dp_cmd,
    output pdq_pkg::dp_status_t dp_status,
    output pdq_pkg::out_item_t  result
);

    pdq_pkg::in_item_t  item_reg;
    pdq_pkg::out_item_t result_reg, result_next;
    pdq_pkg::count_t    occ_reg, occ_next;
    pdq_pkg::word_t     slot_reg  [pdq_pkg::DEPTH];
    pdq_pkg::word_t     slot_next [pdq_pkg::DEPTH];
    pdq_pkg::word_t     prev_w    [pdq_pkg::DEPTH];
    pdq_pkg::word_t     succ_w    [pdq_pkg::DEPTH];
    pdq_pkg::word_t     word_in;
    pdq_pkg::cmp_t      occ_w, pos_w, place_w, take_w;
    pdq_pkg::index_t    place_idx, take_idx;

    // Latch the beat
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
            item_reg <= cmd_in;
    end

    assign word_in = pdq_pkg::word_t'(item_reg.data_in);
    assign occ_w   = pdq_pkg::cmp_t'(occ_reg);
    assign pos_w   = pdq_pkg::cmp_t'(item_reg.position);

    // Decode the operation into indexes and flags
    always_comb
    begin
        dp_status.is_push = 1'b0;
        dp_status.is_pop  = 1'b0;
        dp_status.pos_ok  = 1'b1;
        dp_status.full    = (occ_reg == pdq_pkg::count_t'(pdq_pkg::DEPTH));
        dp_status.empty   = (occ_reg == '0);
        place_w           = '0;
        take_w            = '0;
        unique case (item_reg.operation) inside
            pdq_pkg::OP_PUSH_HEAD:
            begin
                dp_status.is_push = 1'b1;
            end
            pdq_pkg::OP_PUSH_TAIL:
            begin
                dp_status.is_push = 1'b1;
                place_w           = occ_w;
            end
            pdq_pkg::OP_INSERT:
            begin
                dp_status.is_push = 1'b1;
                if (pos_w <= pdq_pkg::cmp_t'(1))
                    place_w = '0;
                else if (pos_w > occ_w)
                    place_w = occ_w;
                else
                    place_w = pos_w - pdq_pkg::cmp_t'(1);
            end
            pdq_pkg::OP_POP_HEAD:
            begin
                dp_status.is_pop = 1'b1;
            end
            pdq_pkg::OP_POP_TAIL:
            begin
                dp_status.is_pop = 1'b1;
                take_w           = occ_w - pdq_pkg::cmp_t'(1);
            end
            pdq_pkg::OP_REMOVE:
            begin
                dp_status.is_pop = 1'b1;
                dp_status.pos_ok = (pos_w != '0) && (pos_w <= occ_w);
                take_w           = pos_w - pdq_pkg::cmp_t'(1);
            end
            default:
            begin
                dp_status.pos_ok = 1'b1;
            end
        endcase
    end

    assign place_idx = place_w[pdq_pkg::IDX_W-1:0];
    assign take_idx  = take_w[pdq_pkg::IDX_W-1:0];

    // Neighbour taps for each cell
    for (genvar g = 0; g < pdq_pkg::DEPTH; g++)
    begin : g_cell
        if (g == 0)
        begin : g_first
            assign prev_w[g] = '0;
        end
        else
        begin : g_prev
            assign prev_w[g] = slot_reg[g-1];
        end
        if (g == pdq_pkg::DEPTH - 1)
        begin : g_last
            assign succ_w[g] = slot_reg[g];
        end
        else
        begin : g_succ
            assign succ_w[g] = slot_reg[g+1];
        end

        // Hold below the index; a place loads the word at it and shifts above it, a take shifts down from it
        always_comb
        begin
            slot_next[g] = slot_reg[g];
            if (dp_cmd.place)
            begin
                if (pdq_pkg::index_t'(g) == place_idx)
                    slot_next[g] = word_in;
                else if (pdq_pkg::index_t'(g) > place_idx)
                    slot_next[g] = prev_w[g];
            end
            else if (dp_cmd.take && (pdq_pkg::index_t'(g) >= take_idx))
            begin
                slot_next[g] = succ_w[g];
            end
        end

        always_ff @(posedge clk)
        begin
            slot_reg[g] <= slot_next[g];
        end
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (dp_cmd.place)
            occ_next = occ_reg + pdq_pkg::count_t'(1);
        else if (dp_cmd.take)
            occ_next = occ_reg - pdq_pkg::count_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else
            occ_reg <= occ_next;
    end

    always_comb
    begin
        result_next.data_out    = '0;
        if (dp_cmd.take)
            result_next.data_out = pdq_pkg::data_field_t'(slot_reg[take_idx]);
        result_next.status      = dp_cmd.res_status;
        result_next.entry_total = pdq_pkg::total_field_t'(occ_next);
        result_next.is_empty    = (occ_next == '0);
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.emit)
            result_reg <= result_next;
    end

    assign result = result_reg;

    `ASSERT_NEVER(a_occ_range, clk, rst_n, occ_reg > pdq_pkg::count_t'(pdq_pkg::DEPTH))
    `ASSERT_PROP(a_place_not_full, clk, rst_n, dp_cmd.place |-> !dp_status.full)
    `ASSERT_PROP(a_take_dec, clk, rst_n,
                 dp_cmd.take |=> occ_reg == $past(occ_reg) - pdq_pkg::count_t'(1))

endmodule

>>> rtl/core/positional_deque_core.sv
// ---------------------------------------------------------------------------
// positional_deque_core
// Ordered store of up to DEPTH words with head, tail and positional access.
// ---------------------------------------------------------------------------
// Usage:
//   Drive an operation beat on cmd and raise start. The beat is taken at the
//   rising edge where start is high and busy is low; busy then stays high for
//   one cycle while the sequencer works on it.
//   Each beat gives exactly one result beat on result, marked by done, which
//   is registered together with the result and stays high for exactly one
//   cycle, so the result is taken at the edge that ends the done pulse.
//   The receiver cannot hold results off: sample result whenever done is high.
//   The core takes no new beat while busy. A new beat may be started in the
//   same cycle that the previous result is shown, since the result sits in
//   its own register.
//   The sequencer first latches the beat; then the slot cells shift in
//   parallel and the result is registered.
//   Pushes into a full store are dropped (status full); pops on an empty
//   store and removals at a bad position leave the store unchanged.
//   Reset (rst_n low) clears the count and the sequencer; slot contents are
//   left as they are and are only ever read below the count.
// ---------------------------------------------------------------------------
module positional_deque_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  pdq_pkg::in_item_t  cmd,
    output logic               busy,
    output logic               done,
    output pdq_pkg::out_item_t result
);

    // Command and status between sequencer and datapath
    pdq_pkg::dp_cmd_t    dp_cmd;
    pdq_pkg::dp_status_t dp_status;

    // Sequencer: accept the beat, choose place or take, strobe the result
    pdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .done      (done),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    // Datapath: slot cells, count and result register
    pdq_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_in    (cmd),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status),
        .result    (result)
    );

endmodule
